// ===== src/bicp_pkg.sv =====
// Shared types, constants and helper functions of the beacon id claim unit.
// Used by bicp_busy_map and beacon_id_claim_protocol_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bicp_pkg;

    // Sizing of the id map and the tick counters.
    localparam int ID_COUNT   = 256;
    localparam int TIMER_BITS = 16;

    // Fixed field widths.
    localparam int ID_BITS     = 8;
    localparam int MARK_BITS   = 32;
    localparam int PERIOD_BITS = 16;

    // The busy map is stored as rows of WORD_BITS ids.
    localparam int WORD_BITS = 32;
    localparam int POS_BITS  = $clog2(WORD_BITS);
    localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_BITS  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAIN_PERIOD  = 1'd1;

    localparam logic [PERIOD_BITS-1:0] SHORT_PERIOD_RESET = 16'd500;
    localparam logic [PERIOD_BITS-1:0] MAIN_PERIOD_RESET  = 16'd3000;

    // Item command codes.
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Message kinds.
    localparam logic [1:0] KIND_INVALID  = 2'd0;
    localparam logic [1:0] KIND_REQUEST  = 2'd1;
    localparam logic [1:0] KIND_RESPONSE = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [1:0]           msg_kind;
        logic [MARK_BITS-1:0] msg_mark;
        logic [ID_BITS-1:0]   msg_param;
        logic [MARK_BITS-1:0] random_mark;
    } in_item_t;

    typedef struct packed {
        logic                 send_request;
        logic [MARK_BITS-1:0] send_mark;
        logic                 running;
        logic [ID_BITS-1:0]   free_id;
    } out_item_t;

    // Read request into the busy map.
    typedef struct packed {
        logic                en;
        logic [ROW_BITS-1:0] row;
    } map_rd_t;

    // Write request into the busy map.
    typedef struct packed {
        logic                 en;
        logic [ROW_BITS-1:0]  row;
        logic [WORD_BITS-1:0] data;
    } map_wr_t;

    // Bits of a row that stand for ids in the range 1 .. ID_COUNT-1.
    function automatic logic [WORD_BITS-1:0] usable_mask(input logic [ROW_BITS-1:0] row);
        logic [WORD_BITS-1:0] m;
        int id;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            id = int'(row) * WORD_BITS + b;
            m[b] = (id >= 1) && (id < ID_COUNT);
        end
        return m;
    endfunction

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [POS_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [POS_BITS-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = POS_BITS'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/bicp_busy_map.sv =====
// Busy map storage: one row of ids per word, single read and single write port.
// Read data is registered; rows never written since reset read as all clear.
// Depends on bicp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bicp_busy_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bicp_pkg::map_rd_t             rd,
    input  wire bicp_pkg::map_wr_t             wr,
    output      logic [bicp_pkg::WORD_BITS-1:0] rd_data
);
    import bicp_pkg::*;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] row_valid_reg;
    logic [WORD_BITS-1:0]  rd_word_reg;
    logic                  rd_row_valid_reg;

    // Row valid bits stand in for clearing the array at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg    <= '0;
            rd_row_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_valid_reg[wr.row] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_row_valid_reg <= row_valid_reg[rd.row];
            end
        end
    end

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row] <= wr.data;
        end
        if (rd.en)
        begin
            rd_word_reg <= mem[rd.row];
        end
    end

    assign rd_data = rd_row_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

// ===== src/beacon_id_claim_protocol_unit.sv =====
// Top level of the beacon id claim unit: handshakes, timers and id search.
// Depends on bicp_pkg and bicp_busy_map.
//
//   Channel  Direction  Handshake                Payload
//   item     in         item_valid / item_stall  bicp_pkg::in_item_t
//   result   out        result_valid / result_stall  bicp_pkg::out_item_t
//   cfg      in         cfg_wen                  cfg_index, cfg_wdata
//
// A tick, a request or an ignored message goes from its transfer to S_DONE,
// which loads the result once the output register is free. A response first
// passes S_RMW, then S_SCAN once per further map row read when its id was the
// lowest free one, up to the last row: a row per cycle on the single read port.
// Reset clears all control state at once; no clearing pass is needed.
// A pending result waits in the output register while result_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module beacon_id_claim_protocol_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output      logic                               item_stall,
    input  wire bicp_pkg::in_item_t                 item,
    output      logic                               result_valid,
    input  wire logic                               result_stall,
    output      bicp_pkg::out_item_t                result,
    input  wire logic                               cfg_wen,
    input  wire logic [bicp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bicp_pkg::PERIOD_BITS-1:0]   cfg_wdata
);
    import bicp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [ROW_BITS-1:0]   LAST_ROW  = ROW_BITS'(WORD_COUNT - 1);

    state_t                 state_reg;
    logic [PERIOD_BITS-1:0] short_period_reg;
    logic [PERIOD_BITS-1:0] main_period_reg;
    logic [MARK_BITS-1:0]   own_mark_reg;
    logic                   request_seen_reg;
    logic [TIMER_BITS-1:0]  poll_count_reg;
    logic [TIMER_BITS-1:0]  main_count_reg;
    logic                   finished_reg;
    logic [ID_BITS-1:0]     free_id_reg;
    logic                   sent_reg;
    logic [MARK_BITS-1:0]   sent_mark_reg;
    logic [ROW_BITS-1:0]    row_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic                   rescan_reg;
    logic                   result_valid_reg;
    out_item_t              result_reg;

    map_rd_t                map_rd;
    map_wr_t                map_wr;
    logic [WORD_BITS-1:0]   map_rd_data;

    logic                   accept;
    logic [TIMER_BITS-1:0]  poll_next;
    logic [TIMER_BITS-1:0]  main_next;
    logic                   main_expired;
    logic                   poll_expired;
    logic                   msg_taken;
    logic                   resp_taken;
    logic [WORD_BITS-1:0]   set_word;
    logic [WORD_BITS-1:0]   scan_word;
    logic [WORD_BITS-1:0]   free_bits;
    logic                   free_found;
    logic [ID_BITS-1:0]     found_id;

    bicp_busy_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (map_rd),
        .wr      (map_wr),
        .rd_data (map_rd_data)
    );

    // Handshake outputs.
    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Saturating tick counters and their expiry checks.
    assign main_next    = (main_count_reg == TIMER_MAX) ? main_count_reg
                                                        : main_count_reg + 1'b1;
    assign poll_next    = (poll_count_reg == TIMER_MAX) ? poll_count_reg
                                                        : poll_count_reg + 1'b1;
    assign main_expired = 32'(main_next) >= 32'(main_period_reg);
    assign poll_expired = 32'(poll_next) >= 32'(short_period_reg);

    // Message filtering: foreign messages only, while still running.
    assign msg_taken  = !finished_reg && (item.command == CMD_MESSAGE)
                        && (item.msg_mark != own_mark_reg);
    assign resp_taken = msg_taken && (item.msg_kind == KIND_RESPONSE)
                        && (32'(item.msg_param) < ID_COUNT);

    // Map row after setting the response bit, and the word under search.
    assign set_word  = map_rd_data | (WORD_BITS'(1) << pos_reg);
    assign scan_word = (state_reg == S_RMW) ? set_word : map_rd_data;
    assign free_bits = ~scan_word & usable_mask(row_reg);
    assign free_found = |free_bits;
    assign found_id  = ID_BITS'({row_reg, lowest_set(free_bits)});

    // Map port requests.
    always_comb
    begin
        map_rd     = '0;
        map_wr     = '0;
        map_wr.row = row_reg;
        map_wr.data = set_word;
        if (state_reg == S_IDLE)
        begin
            map_rd.en  = accept && resp_taken;
            map_rd.row = ROW_BITS'(item.msg_param >> POS_BITS);
        end
        else
        begin
            map_rd.en  = ((state_reg == S_RMW) || (state_reg == S_SCAN))
                         && rescan_reg && !free_found && (row_reg != LAST_ROW);
            map_rd.row = row_reg + 1'b1;
        end
        map_wr.en = (state_reg == S_RMW);
    end

    // Sequencer, protocol state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            short_period_reg <= SHORT_PERIOD_RESET;
            main_period_reg  <= MAIN_PERIOD_RESET;
            own_mark_reg     <= '0;
            request_seen_reg <= 1'b0;
            poll_count_reg   <= '0;
            main_count_reg   <= '0;
            finished_reg     <= 1'b0;
            free_id_reg      <= ID_BITS'(1);
            sent_reg         <= 1'b0;
            sent_mark_reg    <= '0;
            row_reg          <= '0;
            pos_reg          <= '0;
            rescan_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_SHORT_PERIOD: short_period_reg <= cfg_wdata;
                    CFG_MAIN_PERIOD:  main_period_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            // Result register drains on a transfer.
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sent_reg      <= 1'b0;
                        sent_mark_reg <= '0;
                        state_reg     <= S_DONE;
                        if (!finished_reg && (item.command == CMD_TICK))
                        begin
                            if (main_expired)
                            begin
                                finished_reg   <= 1'b1;
                                main_count_reg <= main_next;
                                poll_count_reg <= poll_next;
                            end
                            else if (poll_expired)
                            begin
                                if (request_seen_reg)
                                begin
                                    main_count_reg <= '0;
                                end
                                else
                                begin
                                    main_count_reg <= main_next;
                                    own_mark_reg   <= item.random_mark;
                                    sent_reg       <= 1'b1;
                                    sent_mark_reg  <= item.random_mark;
                                end
                                request_seen_reg <= 1'b0;
                                poll_count_reg   <= '0;
                            end
                            else
                            begin
                                main_count_reg <= main_next;
                                poll_count_reg <= poll_next;
                            end
                        end
                        else if (msg_taken && (item.msg_kind == KIND_REQUEST))
                        begin
                            request_seen_reg <= 1'b1;
                        end
                        else if (resp_taken)
                        begin
                            row_reg    <= ROW_BITS'(item.msg_param >> POS_BITS);
                            pos_reg    <= item.msg_param[POS_BITS-1:0];
                            rescan_reg <= (item.msg_param == free_id_reg);
                            state_reg  <= S_RMW;
                        end
                    end
                end

                // Row is back: S_RMW writes it with bit set; search if needed.
                S_RMW, S_SCAN:
                begin
                    if (!rescan_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (free_found)
                    begin
                        free_id_reg <= found_id;
                        state_reg   <= S_DONE;
                    end
                    else if (row_reg == LAST_ROW)
                    begin
                        free_id_reg <= '0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end

                // Load the result once the output register is free.
                S_DONE:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && (!result_valid_reg || !result_stall))
        begin
            result_reg.send_request <= sent_reg;
            result_reg.send_mark    <= sent_mark_reg;
            result_reg.running      <= !finished_reg;
            result_reg.free_id      <= free_id_reg;
        end
    end

endmodule

`default_nettype wire

// ===== bench/beacon_id_claim_protocol_unit_tb.sv =====
// Self-checking testbench for the beacon id claim unit.
// Drives items and register writes, predicts every result and compares it.
// Depends on bicp_pkg and the beacon_id_claim_protocol_unit RTL.
`timescale 1ns / 1ps

module beacon_id_claim_protocol_unit_tb;
    import bicp_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 16;

    // Message kind that the block must ignore like an invalid one.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    in_item_t                  item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    out_item_t                 result;
    logic                      cfg_wen      = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = CFG_SHORT_PERIOD;
    logic [PERIOD_BITS-1:0]    cfg_wdata    = '0;

    // Predicted state of the claim logic and its registers.
    logic [ID_COUNT-1:0]    busy_ids      = '0;
    logic [MARK_BITS-1:0]   own_mark      = '0;
    logic                   request_heard = 1'b0;
    logic [TIMER_BITS-1:0]  poll_ticks    = '0;
    logic [TIMER_BITS-1:0]  main_ticks    = '0;
    logic                   claim_done    = 1'b0;
    logic [PERIOD_BITS-1:0] short_period  = SHORT_PERIOD_RESET;
    logic [PERIOD_BITS-1:0] main_period   = MAIN_PERIOD_RESET;

    in_item_t  item_backlog[$];
    out_item_t reports_due[$];

    int sender_idle_pct   = 14;
    int receiver_idle_pct = 59;
    bit hold_off_asked    = 1'b0;
    bit hold_off_done     = 1'b0;
    int hold_off_left     = 0;
    int errors            = 0;
    int cycles            = 0;
    int items_sent        = 0;
    int reports_seen      = 0;
    int sends_seen        = 0;
    int fill_next         = 1;
    int pool_slot         = 0;
    logic [MARK_BITS-1:0] mark_pool[4] = '{default: '0};

    beacon_id_claim_protocol_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [ID_BITS-1:0] lowest_free_id();
        for (int id = 1; id < ID_COUNT; id++)
        begin
            if (!busy_ids[id])
            begin
                return ID_BITS'(id);
            end
        end
        return '0;
    endfunction

    function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Applies one item to the predicted state and returns the report it causes.
    task automatic advance_claim(input in_item_t it, output out_item_t rep);
        rep = '0;
        if (!claim_done)
        begin
            if (it.command == CMD_MESSAGE)
            begin
                // A message carrying our own mark is our own echo.
                if (it.msg_mark != own_mark)
                begin
                    if (it.msg_kind == KIND_REQUEST)
                    begin
                        request_heard = 1'b1;
                    end
                    else if (it.msg_kind == KIND_RESPONSE)
                    begin
                        busy_ids[it.msg_param] = 1'b1;
                    end
                end
            end
            else
            begin
                main_ticks = bump(main_ticks);
                poll_ticks = bump(poll_ticks);
                if (main_ticks >= main_period)
                begin
                    claim_done = 1'b1;
                end
                else if (poll_ticks >= short_period)
                begin
                    if (request_heard)
                    begin
                        main_ticks = '0;
                    end
                    else
                    begin
                        own_mark         = it.random_mark;
                        rep.send_request = 1'b1;
                        rep.send_mark    = it.random_mark;
                    end
                    request_heard = 1'b0;
                    poll_ticks    = '0;
                end
            end
        end
        rep.running = !claim_done;
        rep.free_id = lowest_free_id();
    endtask

    task automatic check_field(input string field, input logic [MARK_BITS-1:0] want,
                               input logic [MARK_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Driver: offers the backlog, predicting each item at its transfer.
    always @(posedge clk)
    begin : drive
        out_item_t rep;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
            begin
                advance_claim(item, rep);
                reports_due.push_back(rep);
                items_sent++;
            end
            if (item_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                item       <= item_backlog.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer and drives the receiver stall.
    always @(posedge clk)
    begin : observe
        out_item_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                reports_seen++;
                if (result.send_request)
                begin
                    sends_seen++;
                end
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("send_request", MARK_BITS'(want.send_request),
                                MARK_BITS'(result.send_request));
                    check_field("send_mark", want.send_mark, result.send_mark);
                    check_field("running", MARK_BITS'(want.running),
                                MARK_BITS'(result.running));
                    check_field("free_id", MARK_BITS'(want.free_id),
                                MARK_BITS'(result.free_id));
                end
            end

            // A long hold-off fills the block up so that it stalls its input.
            if (hold_off_asked && !hold_off_done)
            begin
                if (hold_off_left < HOLD_OFF_CYCLES)
                begin
                    hold_off_left++;
                    result_stall <= 1'b1;
                end
                else
                begin
                    hold_off_done = 1'b1;
                    result_stall <= 1'b0;
                end
            end
            else
            begin
                result_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    function automatic in_item_t message(input logic [1:0] kind,
                                         input logic [MARK_BITS-1:0] mark,
                                         input logic [ID_BITS-1:0] param);
        in_item_t m;
        m.command     = CMD_MESSAGE;
        m.msg_kind    = kind;
        m.msg_mark    = mark;
        m.msg_param   = param;
        m.random_mark = $urandom;
        return m;
    endfunction

    function automatic in_item_t tick(input logic [MARK_BITS-1:0] rnd);
        in_item_t t;
        t.command     = CMD_TICK;
        t.msg_kind    = 2'($urandom_range(3));
        t.msg_mark    = $urandom;
        t.msg_param   = 8'($urandom_range(255));
        t.random_mark = rnd;
        return t;
    endfunction

    // Random item: marks are often reused so that echoes of our own requests
    // show up, and response ids sweep upward so that the free id moves.
    function automatic in_item_t random_item(input int tick_pct);
        in_item_t it;
        int pick;
        it.command = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_MESSAGE;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            it.msg_kind = KIND_REQUEST;
        end
        else if (pick < 85)
        begin
            it.msg_kind = KIND_RESPONSE;
        end
        else if (pick < 93)
        begin
            it.msg_kind = KIND_INVALID;
        end
        else
        begin
            it.msg_kind = KIND_UNUSED;
        end
        it.msg_mark = ($urandom_range(99) < 15) ? mark_pool[$urandom_range(3)] : $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            it.msg_param = 8'(fill_next);
            fill_next    = (fill_next + 1) % ID_COUNT;
        end
        else if (pick < 80)
        begin
            it.msg_param = 8'($urandom_range(255));
        end
        else
        begin
            it.msg_param = 8'($urandom_range(8));
        end
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            it.random_mark = '0;
        end
        else if (pick < 20)
        begin
            it.random_mark = '1;
        end
        else
        begin
            it.random_mark = $urandom;
        end
        if (it.command == CMD_TICK)
        begin
            mark_pool[pool_slot] = it.random_mark;
            pool_slot = (pool_slot + 1) % 4;
        end
        return it;
    endfunction

    task automatic queue_random(input int count, input int tick_pct);
        repeat (count)
        begin
            item_backlog.push_back(random_item(tick_pct));
        end
    endtask

    // Waits until every item is through and the block has gone quiet.
    task automatic settle();
        do
        begin
            @(negedge clk);
        end
        while (item_backlog.size() != 0 || item_valid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [PERIOD_BITS-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_SHORT_PERIOD)
        begin
            short_period = val;
        end
        else
        begin
            main_period = val;
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset periods: responses at the id extremes, echoes of the zero
        // reset mark, every message kind, and ticks with extreme marks.
        item_backlog.push_back(message(KIND_RESPONSE, 32'd5, 8'd1));
        item_backlog.push_back(message(KIND_RESPONSE, 32'd5, 8'd0));
        item_backlog.push_back(message(KIND_RESPONSE, 32'd7, 8'd255));
        item_backlog.push_back(message(KIND_RESPONSE, 32'd0, 8'd2));
        item_backlog.push_back(message(KIND_REQUEST, 32'd0, 8'd0));
        item_backlog.push_back(message(KIND_REQUEST, 32'hFFFF_FFFF, 8'd0));
        item_backlog.push_back(message(KIND_INVALID, 32'd9, 8'd3));
        item_backlog.push_back(message(KIND_UNUSED, 32'd9, 8'd3));
        item_backlog.push_back(tick(32'd0));
        item_backlog.push_back(tick(32'hFFFF_FFFF));
        item_backlog.push_back(message(KIND_RESPONSE, 32'hFFFF_FFFF, 8'd2));
        item_backlog.push_back(message(KIND_RESPONSE, 32'd1, 8'd128));
        item_backlog.push_back(message(KIND_REQUEST, 32'h8000_0000, 8'd0));
        item_backlog.push_back(tick($urandom));
        settle();

        // Poll on every tick: a heard request restarts the main timer, then
        // requests go out with a zero mark and an all-ones mark, and an echo
        // of our own request is ignored.
        write_reg(CFG_SHORT_PERIOD, 16'd1);
        write_reg(CFG_MAIN_PERIOD, 16'hFFFF);
        item_backlog.push_back(tick(32'd0));
        item_backlog.push_back(tick(32'd0));
        item_backlog.push_back(tick(32'hFFFF_FFFF));
        item_backlog.push_back(message(KIND_REQUEST, 32'hFFFF_FFFF, 8'd0));
        item_backlog.push_back(tick(32'h0000_007B));
        item_backlog.push_back(message(KIND_REQUEST, 32'd0, 8'd0));
        item_backlog.push_back(tick($urandom));
        settle();

        // Both periods at their maximum: the timers only count.
        write_reg(CFG_SHORT_PERIOD, 16'hFFFF);
        queue_random(100, 40);
        settle();

        sender_idle_pct   = 59;
        receiver_idle_pct = 14;
        write_reg(CFG_SHORT_PERIOD, 16'd1);
        queue_random(150, 40);
        settle();

        // A zero short period polls on the first tick every time.
        write_reg(CFG_SHORT_PERIOD, 16'd0);
        write_reg(CFG_MAIN_PERIOD, 16'd60000);
        queue_random(150, 40);
        settle();

        // No idling from here on; the receiver holds off once at the start.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_reg(CFG_SHORT_PERIOD, 16'd3);
        write_reg(CFG_MAIN_PERIOD, 16'd40);
        hold_off_asked = 1'b1;
        queue_random(450, 40);
        settle();

        // Fill every id still free so that the search comes up empty.
        write_reg(CFG_SHORT_PERIOD, 16'd2);
        write_reg(CFG_MAIN_PERIOD, 16'd25);
        for (int id = 1; id < ID_COUNT; id++)
        begin
            if (!busy_ids[id])
            begin
                item_backlog.push_back(message(KIND_RESPONSE, ~own_mark, 8'(id)));
            end
        end
        queue_random(250, 45);
        settle();

        // Restart the main timer from a known point, let it count, then
        // lower main_period under the count so the next tick ends the claim.
        write_reg(CFG_SHORT_PERIOD, 16'd1);
        write_reg(CFG_MAIN_PERIOD, 16'hFFFF);
        item_backlog.push_back(message(KIND_REQUEST, ~own_mark, 8'd0));
        item_backlog.push_back(tick($urandom));
        settle();
        write_reg(CFG_SHORT_PERIOD, 16'd2);
        write_reg(CFG_MAIN_PERIOD, 16'd7);
        repeat (5) item_backlog.push_back(tick($urandom));
        settle();
        write_reg(CFG_MAIN_PERIOD, 16'd1);
        item_backlog.push_back(tick($urandom));
        queue_random(8, 50);
        settle();

        $display("Run covered %0d items and %0d results, %0d of them sending a request.",
                 items_sent, reports_seen, sends_seen);
        $display("Periods went from 0 to 65535; the claim ended %s with free id %0d.",
                 claim_done ? "finished" : "still running", lowest_free_id());
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bicp_pkg.sv
src/bicp_busy_map.sv
src/beacon_id_claim_protocol_unit.sv
bench/beacon_id_claim_protocol_unit_tb.sv
